// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros: shared assertion shorthands
// clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge
`define DSWQ_ASSERT(name, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dswq assertion failed");

// when pre holds, post must hold in the following cycle
`define DSWQ_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("dswq assertion failed");

`endif

// File: rtl/dswq_pkg.sv
// ---------------------------------------------------------------------------
// dswq_pkg
// types, constants and the level-to-code conversion of the dac word queue
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dswq_pkg;

    localparam int WORD_W  = 16;
    localparam int LEVEL_W = 12;
    localparam int CODE_W  = 8;
    localparam int BIT_W   = 4;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam logic [LEVEL_W-1:0] MV_MAX   = 12'd3275;
    localparam logic [12:0]        MV_GAIN  = 13'd5154;
    // round half (32768) minus the 5 mv zero offset times the gain
    localparam logic [24:0]        ACC_BIAS = 25'd6998;
    localparam logic [BIT_W-1:0]   LAST_BIT = 4'd15;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctl_t;

    typedef struct packed {
        logic start;
        logic active;
        logic data;
        logic done;
        logic in_frame_next;
    } frame_status_t;

    typedef struct packed {
        logic serial_data;
        logic sync_n;
        logic clock_pulse;
        logic frame_done;
        logic busy_res;
        logic dropped;
    } result_t;

    function automatic logic [CODE_W-1:0] level_to_code(input logic [LEVEL_W-1:0] level);
        logic [LEVEL_W-1:0] mv;
        logic [24:0]        acc;
        logic [8:0]         code_wide;
        mv        = (level > MV_MAX) ? MV_MAX : level;
        acc       = 25'(mv) * 25'(MV_GAIN) + ACC_BIAS;
        code_wide = acc[24:16];
        return (code_wide > 9'd255) ? 8'hFF : code_wide[CODE_W-1:0];
    endfunction

endpackage

// File: rtl/dswq_cmd_if.sv
// ---------------------------------------------------------------------------
// dswq_cmd_if
// command channel: dac writes and bit-clock ticks
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dswq_cmd_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [1:0]  channel;
    logic [1:0]  mode_bits;
    logic [11:0] level_mv;

    modport source (output valid, func, channel, mode_bits, level_mv, input ready);
    modport sink   (input valid, func, channel, mode_bits, level_mv, output ready);
endinterface

// File: rtl/dswq_res_if.sv
// ---------------------------------------------------------------------------
// dswq_res_if
// result channel: serial line levels and status per command
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface dswq_res_if;
    logic valid;
    logic ready;
    logic serial_data;
    logic sync_n;
    logic clock_pulse;
    logic frame_done;
    logic busy_res;
    logic dropped;

    modport source (output valid, serial_data, sync_n, clock_pulse, frame_done,
                    busy_res, dropped, input ready);
    modport sink   (input valid, serial_data, sync_n, clock_pulse, frame_done,
                    busy_res, dropped, output ready);
endinterface

// File: rtl/dac_serial_word_queue_top.sv
// ---------------------------------------------------------------------------
// dac_serial_word_queue_top
// queues packed dac words and shifts them out msb first, one bit per tick
//
// cmd carries one word per handshake: func low is a write that converts
// level_mv to an 8-bit code and queues channel, mode_bits and code as a
// 16-bit word; func high is one bit-clock tick of the serial frame.
// res returns exactly one word per command, in order: data line, sync_n,
// clock pulse, frame done, busy and dropped flags.
// a command is taken every cycle while cmd.ready is high; its result is registered before it is valid on res.
// the queue is a row of QUEUE_DEPTH cells that shift toward the head on each
// frame start; a write to a full queue is dropped and flagged.
// a two-word output buffer keeps cmd ready while one result waits, so cmd
// stalls only after res has held back two results.
// reset empties the queue, ends any frame and clears the output buffer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dac_serial_word_queue_top
    import dswq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    dswq_cmd_if.sink          cmd,
    dswq_res_if.source        res
);

    logic                   cmd_fire;
    logic                   res_pop;
    logic                   is_write;
    logic                   is_tick;
    logic                   full;
    logic [WORD_W-1:0]      new_word;
    queue_ctl_t             qctl;
    frame_status_t          fstat;
    result_t                result;
    logic [QUEUE_DEPTH-1:0] q_valid;
    logic [WORD_W-1:0]      q_word [QUEUE_DEPTH];

    result_t out_reg;
    logic    out_valid_reg;
    result_t skid_reg;
    logic    skid_valid_reg;

    assign cmd.ready = ~skid_valid_reg;
    assign cmd_fire  = cmd.valid & cmd.ready;
    assign res_pop   = out_valid_reg & res.ready;
    assign is_write  = cmd_fire & (cmd.func == FUNC_WRITE);
    assign is_tick   = cmd_fire & (cmd.func == FUNC_TICK);
    assign full      = q_valid[QUEUE_DEPTH-1];
    assign new_word  = {cmd.channel, cmd.mode_bits, level_to_code(cmd.level_mv), 4'b0000};

    assign qctl.push = is_write & ~full;
    assign qctl.pop  = fstat.start;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic              prev_v;
            logic              next_v;
            logic [WORD_W-1:0] next_w;
            if (gi == 0)
            begin : g_head
                assign prev_v = 1'b1;
            end
            else
            begin : g_body
                assign prev_v = q_valid[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_tail
                assign next_v = 1'b0;
                assign next_w = '0;
            end
            else
            begin : g_link
                assign next_v = q_valid[gi+1];
                assign next_w = q_word[gi+1];
            end
            dswq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (qctl),
                .head       (gi == 0),
                .prev_valid (prev_v),
                .next_valid (next_v),
                .next_word  (next_w),
                .new_word   (new_word),
                .valid      (q_valid[gi]),
                .word       (q_word[gi])
            );
        end
    endgenerate

    dswq_shifter u_shifter (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (is_tick),
        .head_valid (q_valid[0]),
        .head_word  (q_word[0]),
        .status     (fstat)
    );

    always_comb
    begin
        if (cmd.func == FUNC_WRITE)
        begin
            result.serial_data = 1'b0;
            // no tick on a write, so the frame flag holds its current value
            result.sync_n      = ~fstat.in_frame_next;
            result.clock_pulse = 1'b0;
            result.frame_done  = 1'b0;
            // a write either queues or finds the queue full: never empty after
            result.busy_res    = 1'b1;
            result.dropped     = full;
        end
        else
        begin
            result.serial_data = fstat.data;
            result.sync_n      = ~fstat.active;
            result.clock_pulse = fstat.active;
            result.frame_done  = fstat.done;
            result.busy_res    = (fstat.start ? q_valid[1] : q_valid[0])
                                 | fstat.in_frame_next;
            result.dropped     = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (res_pop)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (cmd_fire)
        begin
            if (out_valid_reg && !res_pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (res_pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (res_pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (cmd_fire)
        begin
            if (out_valid_reg && !res_pop)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.serial_data = out_reg.serial_data;
    assign res.sync_n      = out_reg.sync_n;
    assign res.clock_pulse = out_reg.clock_pulse;
    assign res.frame_done  = out_reg.frame_done;
    assign res.busy_res    = out_reg.busy_res;
    assign res.dropped     = out_reg.dropped;

    // occupied cells always form a run starting at the head
    `DSWQ_ASSERT(a_queue_packed, $onehot({1'b0, q_valid} + 1'b1))
    `DSWQ_ASSERT(a_skid_behind_out, !skid_valid_reg || out_valid_reg)
    `DSWQ_ASSERT_NEXT(a_full_write_keeps_queue, is_write && full, q_valid == $past(q_valid))
    `DSWQ_ASSERT_NEXT(a_start_pops_head, fstat.start && !q_valid[1], !q_valid[0])

endmodule

// File: rtl/dswq_cell.sv
// ---------------------------------------------------------------------------
// dswq_cell
// one queue slot; takes its neighbor's word on pop, the new word on push
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dswq_cell
    import dswq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  queue_ctl_t        ctl,
    input  logic              head,
    input  logic              prev_valid,
    input  logic              next_valid,
    input  logic [WORD_W-1:0] next_word,
    input  logic [WORD_W-1:0] new_word,
    output logic              valid,
    output logic [WORD_W-1:0] word
);

    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic              sh_valid;
    logic              prev_sh_valid;
    logic              load;

    always_comb
    begin
        sh_valid      = ctl.pop ? next_valid : valid_reg;
        word_next     = ctl.pop ? next_word : word_reg;
        // first empty slot after any shift takes the new word
        prev_sh_valid = head | (ctl.pop ? valid_reg : prev_valid);
        load          = ctl.push & ~sh_valid & prev_sh_valid;
        valid_next    = sh_valid | load;
        if (load)
        begin
            word_next = new_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule

// File: rtl/dswq_shifter.sv
// ---------------------------------------------------------------------------
// dswq_shifter
// msb-first frame shifter with bit counter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dswq_shifter
    import dswq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick,
    input  logic              head_valid,
    input  logic [WORD_W-1:0] head_word,
    output frame_status_t     status
);

    logic [WORD_W-1:0] shift_reg;
    logic [WORD_W-1:0] shift_next;
    logic [BIT_W-1:0]  bit_index_reg;
    logic [BIT_W-1:0]  bit_index_next;
    logic              in_frame_reg;
    logic              in_frame_next;
    logic [WORD_W-1:0] cur_word;
    logic [BIT_W-1:0]  cur_index;

    always_comb
    begin
        status.start   = tick & ~in_frame_reg & head_valid;
        status.active  = tick & (in_frame_reg | head_valid);
        cur_word       = status.start ? head_word : shift_reg;
        cur_index      = status.start ? '0 : bit_index_reg;
        status.data    = status.active & cur_word[WORD_W-1];
        status.done    = status.active & (cur_index == LAST_BIT);
        shift_next     = shift_reg;
        bit_index_next = bit_index_reg;
        in_frame_next  = in_frame_reg;
        if (status.active)
        begin
            if (status.done)
            begin
                in_frame_next  = 1'b0;
                bit_index_next = '0;
            end
            else
            begin
                in_frame_next  = 1'b1;
                shift_next     = {cur_word[WORD_W-2:0], 1'b0};
                bit_index_next = cur_index + 1'b1;
            end
        end
        status.in_frame_next = in_frame_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_index_reg <= '0;
            in_frame_reg  <= 1'b0;
        end
        else
        begin
            bit_index_reg <= bit_index_next;
            in_frame_reg  <= in_frame_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
    end

endmodule

// File: sim/dac_serial_word_queue_top_tb.sv
// ---------------------------------------------------------------------------
// dac_serial_word_queue_top_tb
// checks the dac word queue: level conversion, queue overflow and the serial
// frame, word by word against an in-bench model of the queue and shifter.
// a short table of directed commands runs first, then random write/tick mixes
// under three idling patterns on the command and result channels
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dac_serial_word_queue_top_tb
    import dswq_pkg::*;
();

    localparam int DEPTH        = 8;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_WORDS = 650;
    localparam int DRAIN_CYCLES = 8;

    localparam int LEVEL_CLAMP = 3275;
    localparam int ZERO_MV     = 5;
    localparam int GAIN_Q16    = 5154;
    localparam int HALF_Q16    = 32768;
    localparam int CODE_TOP    = 255;

    typedef struct packed {
        logic               func;
        logic [1:0]         channel;
        logic [1:0]         mode_bits;
        logic [LEVEL_W-1:0] level_mv;
    } dac_cmd_t;

    typedef struct packed {
        logic    typed;
        result_t want;
    } fixed_result_t;

    typedef struct packed {
        dac_cmd_t      cmd;
        fixed_result_t fixed;
    } table_row_t;

    // serial_data, sync_n, clock_pulse, frame_done, busy_res, dropped
    localparam result_t R_IDLE       = 6'b010000;
    localparam result_t R_QUEUED     = 6'b010010;
    localparam result_t R_DROP_IDLE  = 6'b010011;
    localparam result_t R_DROP_FRAME = 6'b000011;
    localparam result_t R_NONE       = 6'b000000;

    localparam int TABLE_LEN = 25;
    localparam table_row_t DIRECTED [TABLE_LEN] = '{
        '{'{FUNC_TICK,  2'd0, 2'd0, 12'd0},    '{1'b1, R_IDLE}},
        '{'{FUNC_WRITE, 2'd0, 2'd0, 12'd0},    '{1'b1, R_QUEUED}},
        '{'{FUNC_WRITE, 2'd3, 2'd3, 12'd4095}, '{1'b1, R_QUEUED}},
        '{'{FUNC_WRITE, 2'd1, 2'd2, 12'd5},    '{1'b1, R_QUEUED}},
        '{'{FUNC_WRITE, 2'd2, 2'd1, 12'd3275}, '{1'b1, R_QUEUED}},
        '{'{FUNC_WRITE, 2'd0, 2'd3, 12'd3276}, '{1'b1, R_QUEUED}},
        '{'{FUNC_WRITE, 2'd3, 2'd0, 12'd6},    '{1'b1, R_QUEUED}},
        '{'{FUNC_WRITE, 2'd1, 2'd1, 12'd2048}, '{1'b1, R_QUEUED}},
        '{'{FUNC_WRITE, 2'd2, 2'd2, 12'd1365}, '{1'b1, R_QUEUED}},
        // queue full, no frame yet
        '{'{FUNC_WRITE, 2'd3, 2'd3, 12'd4094}, '{1'b1, R_DROP_IDLE}},
        '{'{FUNC_TICK,  2'd0, 2'd0, 12'd0},    '{1'b0, R_NONE}},
        // write while the frame shifts
        '{'{FUNC_WRITE, 2'd2, 2'd0, 12'd1},    '{1'b0, R_NONE}},
        '{'{FUNC_WRITE, 2'd1, 2'd3, 12'd3274}, '{1'b1, R_DROP_FRAME}},
        '{'{FUNC_TICK,  2'd1, 2'd2, 12'd2730}, '{1'b0, R_NONE}},
        '{'{FUNC_TICK,  2'd0, 2'd0, 12'd0},    '{1'b0, R_NONE}},
        '{'{FUNC_TICK,  2'd0, 2'd0, 12'd0},    '{1'b0, R_NONE}},
        '{'{FUNC_TICK,  2'd0, 2'd0, 12'd0},    '{1'b0, R_NONE}},
        '{'{FUNC_TICK,  2'd0, 2'd0, 12'd0},    '{1'b0, R_NONE}},
        '{'{FUNC_TICK,  2'd0, 2'd0, 12'd0},    '{1'b0, R_NONE}},
        '{'{FUNC_TICK,  2'd0, 2'd0, 12'd0},    '{1'b0, R_NONE}},
        '{'{FUNC_TICK,  2'd0, 2'd0, 12'd0},    '{1'b0, R_NONE}},
        '{'{FUNC_TICK,  2'd0, 2'd0, 12'd0},    '{1'b0, R_NONE}},
        '{'{FUNC_TICK,  2'd0, 2'd0, 12'd0},    '{1'b0, R_NONE}},
        '{'{FUNC_TICK,  2'd0, 2'd0, 12'd0},    '{1'b0, R_NONE}},
        '{'{FUNC_TICK,  2'd3, 2'd1, 12'd4095}, '{1'b0, R_NONE}}
    };

    logic clk;
    logic rst_n;

    dswq_cmd_if cmd_ch ();
    dswq_res_if res_ch ();

    dac_serial_word_queue_top #(
        .QUEUE_DEPTH (DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    // model of the word queue and the shifter
    logic [WORD_W-1:0] model_words [DEPTH];
    int                model_count;
    int                model_rd;
    int                model_wr;
    logic [WORD_W-1:0] model_shift;
    int                model_bit;
    logic              model_framing;

    result_t       pending_line_results [$];
    fixed_result_t fixed_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int error_count;
    int cycle_count;
    int write_count;
    int tick_count;
    int frame_count;
    int drop_count;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [CODE_W-1:0] mv_to_code(input logic [LEVEL_W-1:0] level);
        int mv;
        int acc;
        mv  = (int'(level) > LEVEL_CLAMP) ? LEVEL_CLAMP : int'(level);
        acc = (mv - ZERO_MV) * GAIN_Q16 + HALF_Q16;
        if (acc < 0)
            return '0;
        acc = acc >>> 16;
        return (acc > CODE_TOP) ? CODE_W'(CODE_TOP) : CODE_W'(acc);
    endfunction

    function automatic result_t predict_line_levels(input dac_cmd_t c);
        result_t r;
        r = R_IDLE;
        if (c.func == FUNC_WRITE)
        begin
            if (model_count >= DEPTH)
                r.dropped = 1'b1;
            else
            begin
                model_words[model_wr] = {c.channel, c.mode_bits, mv_to_code(c.level_mv), 4'h0};
                model_wr              = (model_wr + 1) % DEPTH;
                model_count++;
            end
            r.sync_n = !model_framing;
        end
        else
        begin
            if (!model_framing && model_count > 0)
            begin
                model_shift   = model_words[model_rd];
                model_rd      = (model_rd + 1) % DEPTH;
                model_count--;
                model_framing = 1'b1;
                model_bit     = 0;
            end
            if (model_framing)
            begin
                r.serial_data = model_shift[WORD_W-1];
                r.sync_n      = 1'b0;
                r.clock_pulse = 1'b1;
                if (model_bit >= WORD_W - 1)
                begin
                    r.frame_done  = 1'b1;
                    model_framing = 1'b0;
                    model_bit     = 0;
                end
                else
                begin
                    model_shift = model_shift << 1;
                    model_bit++;
                end
            end
        end
        r.busy_res = (model_count > 0) || model_framing;
        return r;
    endfunction

    // level picks lean on the clamp and zero-offset edges
    function automatic dac_cmd_t random_cmd(input int write_pct);
        dac_cmd_t c;
        int       pick;
        c.func      = ($urandom_range(0, 99) < write_pct) ? FUNC_WRITE : FUNC_TICK;
        c.channel   = 2'($urandom_range(0, 3));
        c.mode_bits = 2'($urandom_range(0, 3));
        pick        = $urandom_range(0, 15);
        case (pick)
            0: c.level_mv = 12'd0;
            1: c.level_mv = 12'd4095;
            2: c.level_mv = 12'($urandom_range(0, 12));
            3: c.level_mv = 12'($urandom_range(3260, 3290));
            default: c.level_mv = 12'($urandom);
        endcase
        return c;
    endfunction

    task automatic send_cmd(input dac_cmd_t c, input fixed_result_t fixed);
        fixed_results.push_back(fixed);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.func      <= c.func;
        cmd_ch.channel   <= c.channel;
        cmd_ch.mode_bits <= c.mode_bits;
        cmd_ch.level_mv  <= c.level_mv;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // command side: predict each accepted word
    always @(posedge clk)
    begin : cmd_monitor
        dac_cmd_t      c;
        result_t       r;
        fixed_result_t f;
        if (rst_n && cmd_ch.valid && cmd_ch.ready)
        begin
            c = {cmd_ch.func, cmd_ch.channel, cmd_ch.mode_bits, cmd_ch.level_mv};
            r = predict_line_levels(c);
            f = fixed_results.pop_front();
            if (f.typed)
                r = f.want;
            pending_line_results.push_back(r);
            if (c.func == FUNC_WRITE)
                write_count++;
            else
                tick_count++;
        end
    end

    // result side: compare with the oldest expectation
    always @(posedge clk)
    begin : res_monitor
        result_t got;
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = {res_ch.serial_data, res_ch.sync_n, res_ch.clock_pulse,
                   res_ch.frame_done, res_ch.busy_res, res_ch.dropped};
            if (pending_line_results.size() == 0)
            begin
                error_count++;
                $display("%0t: result word with nothing expected: got data=%b sync_n=%b",
                         $realtime, got.serial_data, got.sync_n);
            end
            else
            begin
                want = pending_line_results.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    $display("%0t: mismatch, expected data=%b sync_n=%b clk=%b done=%b busy=%b drop=%b",
                             $realtime, want.serial_data, want.sync_n, want.clock_pulse,
                             want.frame_done, want.busy_res, want.dropped);
                    $display("%0t:              got data=%b sync_n=%b clk=%b done=%b busy=%b drop=%b",
                             $realtime, got.serial_data, got.sync_n, got.clock_pulse,
                             got.frame_done, got.busy_res, got.dropped);
                end
                frame_count += got.frame_done;
                drop_count  += got.dropped;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: run did not finish within %0d cycles", $realtime, CYCLE_LIMIT);
            $display("** dac_serial_word_queue_top: FAILED **");
            $finish;
        end
    end

    initial
    begin : stimulus
        int ph;
        int n;
        int write_pct;
        int per_phase;

        rst_n            <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.func      <= FUNC_WRITE;
        cmd_ch.channel   <= '0;
        cmd_ch.mode_bits <= '0;
        cmd_ch.level_mv  <= '0;

        send_idle_pct = 0;
        recv_idle_pct = 0;
        error_count   = 0;
        cycle_count   = 0;
        write_count   = 0;
        tick_count    = 0;
        frame_count   = 0;
        drop_count    = 0;
        model_count   = 0;
        model_rd      = 0;
        model_wr      = 0;
        model_shift   = '0;
        model_bit     = 0;
        model_framing = 1'b0;
        foreach (model_words[i])
            model_words[i] = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 23;
        recv_idle_pct = 57;
        for (int i = 0; i < TABLE_LEN; i++)
            send_cmd(DIRECTED[i].cmd, DIRECTED[i].fixed);

        per_phase = RANDOM_WORDS / 3;
        write_pct = 10;
        for (ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 23;
                    recv_idle_pct = 57;
                end
                1:
                begin
                    // hold the command side until the result side catches up
                    cmd_ch.valid <= 1'b0;
                    @(posedge clk);
                    while (pending_line_results.size() != 0)
                        @(posedge clk);
                    send_idle_pct = 57;
                    recv_idle_pct = 23;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (n = 0; n < per_phase + 1; n++)
            begin
                // mix changes so the queue runs empty, steady and overflowing
                if (n % 40 == 0)
                begin
                    case ($urandom_range(0, 3))
                        0: write_pct = 4;
                        1: write_pct = 8;
                        2: write_pct = 25;
                        default: write_pct = 65;
                    endcase
                end
                send_cmd(random_cmd(write_pct), '{1'b0, R_NONE});
            end
        end
        cmd_ch.valid <= 1'b0;
        @(posedge clk);

        while (pending_line_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d writes and %0d ticks, %0d frames shifted out,",
                 write_count, tick_count, frame_count);
        $display("%0d writes dropped on a full queue, %0d mismatches", drop_count, error_count);
        if (error_count == 0)
            $display("** dac_serial_word_queue_top: PASSED **");
        else
            $display("** dac_serial_word_queue_top: FAILED **");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/dswq_pkg.sv
rtl/dswq_cmd_if.sv
rtl/dswq_res_if.sv
rtl/dswq_cell.sv
rtl/dswq_shifter.sv
rtl/dac_serial_word_queue_top.sv
sim/dac_serial_word_queue_top_tb.sv
